// ===== design/fcl_pkg.sv =====
// shared constants, codes and types of the fully connected layer
`timescale 1ns / 1ps
package fcl_pkg;

   // layer limits
   localparam int MAX_IN       = 1024;
   localparam int MAX_OUT      = 64;
   localparam int DATA_WIDTH   = 16;
   localparam int ACC_W        = 40;
   localparam int PROD_W       = 2 * DATA_WIDTH;
   localparam int SUM_W        = ACC_W + 1;
   localparam int POS_W        = $clog2(MAX_IN);
   localparam int NI_W         = POS_W + 1;
   localparam int K_W          = $clog2(MAX_OUT);
   localparam int NO_W         = K_W + 1;
   localparam int WEIGHT_DEPTH = MAX_IN * MAX_OUT;
   localparam int WA_W         = $clog2(WEIGHT_DEPTH);

   // field and register widths
   localparam int ACTION_W     = 2;
   localparam int IDX_W        = 16;
   localparam int OUT_IDX_W    = 6;
   localparam int IN_SIZE_W    = 11;
   localparam int N_OUT_W      = 7;
   localparam int FRAC_W       = 4;
   localparam int CSR_ADDR_W   = 4;
   localparam int CSR_DATA_W   = 16;

   // saturation bounds
   localparam logic signed [SUM_W-1:0] SAT_HI = SUM_W'((2 ** (DATA_WIDTH - 1)) - 1);
   localparam logic signed [SUM_W-1:0] SAT_LO = -SAT_HI - SUM_W'(1);

   // request actions
   localparam logic [ACTION_W-1:0] ACT_WEIGHT = 2'd0;
   localparam logic [ACTION_W-1:0] ACT_BIAS   = 2'd1;
   localparam logic [ACTION_W-1:0] ACT_FEED   = 2'd2;

   // register indexes
   localparam logic [CSR_ADDR_W-1:0] CSR_IN_SIZE  = 4'd0;
   localparam logic [CSR_ADDR_W-1:0] CSR_N_OUT    = 4'd1;
   localparam logic [CSR_ADDR_W-1:0] CSR_RELU     = 4'd2;
   localparam logic [CSR_ADDR_W-1:0] CSR_FRAC     = 4'd3;

   // sequencer states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MAC,
      ST_DRAIN,
      ST_RD,
      ST_SUM,
      ST_SAT,
      ST_HOLD
   } state_type;

endpackage

// ===== design/fcl_req_if.sv =====
// request channel: weight, bias and activation writes
`timescale 1ns / 1ps
interface fcl_req_if import fcl_pkg::*; ();
   logic                         valid;
   logic                         ready;
   logic [ACTION_W-1:0]          action;
   logic [IDX_W-1:0]             index;
   logic signed [DATA_WIDTH-1:0] value;

   modport source (output valid, output action, output index, output value, input ready);
   modport sink   (input valid, input action, input index, input value, output ready);
endinterface

// ===== design/fcl_rsp_if.sv =====
// result channel: one layer output per transfer
`timescale 1ns / 1ps
interface fcl_rsp_if import fcl_pkg::*; ();
   logic                         valid;
   logic                         ready;
   logic signed [DATA_WIDTH-1:0] result_value;
   logic [OUT_IDX_W-1:0]         out_index;
   logic                         last;
   logic [OUT_IDX_W-1:0]         best_index;
   logic signed [DATA_WIDTH-1:0] best_value;
   logic                         saturated;

   modport source (output valid, output result_value, output out_index, output last,
                   output best_index, output best_value, output saturated, input ready);
   modport sink   (input valid, input result_value, input out_index, input last,
                   input best_index, input best_value, input saturated, output ready);
endinterface

// ===== design/fcl_csr_if.sv =====
// configuration write channel
`timescale 1ns / 1ps
interface fcl_csr_if import fcl_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic [CSR_ADDR_W-1:0] addr;
   logic [CSR_DATA_W-1:0] data;

   modport source (output valid, output addr, output data, input ready);
   modport sink   (input valid, input addr, input data, output ready);
endinterface

// ===== design/fcl_ram.sv =====
// generic single write port ram with registered read
`timescale 1ns / 1ps
module fcl_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];

   // write and registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end
endmodule

// ===== design/fully_connected_layer_relu.sv =====
// fully connected layer with saturation, optional relu and running argmax
//
//   channel  dir  handshake          payload
//   req_bus  in   valid / ready      action, index, value
//   rsp_bus  out  valid / ready      result_value, out_index, last, best_index,
//                                    best_value, saturated
//   csr_bus  in   valid / ready (=1) addr, data
//
// a weight or bias write is accepted in the idle state. an activation passes through
// the accept step, one accumulator read-modify-write issued per output, then a drain
// state that waits until the multiply and write-back stages are empty. after the last
// activation of a sample each result passes through the memory read, add, clip and
// present states, plus any rsp stall. one item is worked on at a time; req_ready is low
// while busy. synchronous reset clears control state; no memory clearing pass is needed.
`timescale 1ns / 1ps
module fully_connected_layer_relu import fcl_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   fcl_req_if.sink   req_bus,
   fcl_rsp_if.source rsp_bus,
   fcl_csr_if.sink   csr_bus
);
   // configuration registers
   logic [IN_SIZE_W-1:0]  in_size_ff;
   logic [N_OUT_W-1:0]    n_out_ff;
   logic                  relu_ff;
   logic [FRAC_W-1:0]     frac_ff;

   // sequencer
   state_type                    state_ff, state_in;
   logic [K_W-1:0]               k_ff, k_in;
   logic [WA_W-1:0]              addr_ff, addr_in;
   logic [POS_W-1:0]             pos_ff, pos_in;
   logic                         done_ff, done_in;
   logic signed [DATA_WIDTH-1:0] act_ff, act_in;
   logic [MAX_OUT-1:0]           acc_vld_ff, acc_vld_in;
   logic                         acc_clr;

   // multiply-accumulate pipeline
   logic                     s1_vld_ff, s1_vld_in;
   logic [K_W-1:0]           s1_k_ff, s1_k_in;
   logic                     s1_accv_ff, s1_accv_in;
   logic                     s2_vld_ff, s2_vld_in;
   logic [K_W-1:0]           s2_k_ff, s2_k_in;
   logic signed [PROD_W-1:0] prod_ff, prod_in;
   logic signed [ACC_W-1:0]  s2_acc_ff, s2_acc_in;
   logic signed [ACC_W-1:0]  acc_wr_data;

   // result path
   logic                         o_accv_ff, o_accv_in;
   logic signed [SUM_W-1:0]      sum_ff, sum_in;
   logic signed [DATA_WIDTH-1:0] best_val_ff, best_val_in;
   logic [K_W-1:0]               best_idx_ff, best_idx_in;
   logic                         rsp_vld_ff, rsp_vld_in;
   logic signed [DATA_WIDTH-1:0] res_ff, res_in;
   logic [K_W-1:0]               oidx_ff, oidx_in;
   logic                         last_ff, last_in;
   logic                         sat_ff, sat_in;

   // memory ports
   logic [DATA_WIDTH-1:0] w_rd;
   logic [DATA_WIDTH-1:0] b_rd;
   logic [ACC_W-1:0]      acc_rd;
   logic                  w_wr_en;
   logic                  b_wr_en;

   // effective sizes
   logic [NI_W-1:0] ni;
   logic [NO_W-1:0] no;
   logic            req_fire;
   logic            k_is_last;

   // output datapath helpers
   logic signed [ACC_W-1:0]      acc_sel;
   logic signed [ACC_W-1:0]      acc_shift;
   logic signed [DATA_WIDTH-1:0] clip_val;
   logic                         clip_sat;
   logic signed [DATA_WIDTH-1:0] relu_val;

   // size clamping
   assign ni = (in_size_ff == '0) ? NI_W'(1) :
               (32'(in_size_ff) > MAX_IN) ? NI_W'(MAX_IN) : NI_W'(in_size_ff);
   assign no = (n_out_ff == '0) ? NO_W'(1) :
               (32'(n_out_ff) > MAX_OUT) ? NO_W'(MAX_OUT) : NO_W'(n_out_ff);

   assign req_bus.ready = (state_ff == ST_IDLE);
   assign req_fire      = req_bus.valid && req_bus.ready;
   assign k_is_last     = (NO_W'(k_ff) == (no - NO_W'(1)));
   assign csr_bus.ready = 1'b1;

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         in_size_ff  <= IN_SIZE_W'(784);
         n_out_ff    <= N_OUT_W'(50);
         relu_ff     <= 1'b1;
         frac_ff     <= FRAC_W'(8);
      end else if (csr_bus.valid) begin
         unique case (csr_bus.addr)
            CSR_IN_SIZE:  in_size_ff  <= csr_bus.data[IN_SIZE_W-1:0];
            CSR_N_OUT:    n_out_ff    <= csr_bus.data[N_OUT_W-1:0];
            CSR_RELU:     relu_ff     <= csr_bus.data[0];
            CSR_FRAC:     frac_ff     <= csr_bus.data[FRAC_W-1:0];
            default: ;
         endcase
      end
   end

   // weight, bias and accumulator memories
   assign w_wr_en = req_fire && (req_bus.action == ACT_WEIGHT)
                    && (32'(req_bus.index) < WEIGHT_DEPTH);
   assign b_wr_en = req_fire && (req_bus.action == ACT_BIAS)
                    && (32'(req_bus.index) < MAX_OUT);

   fcl_ram #(.WIDTH(DATA_WIDTH), .DEPTH(WEIGHT_DEPTH)) u_weight_ram (
      .clock   (clock),
      .wr_en   (w_wr_en),
      .wr_addr (req_bus.index[WA_W-1:0]),
      .wr_data (req_bus.value),
      .rd_addr (addr_ff),
      .rd_data (w_rd)
   );

   fcl_ram #(.WIDTH(DATA_WIDTH), .DEPTH(MAX_OUT)) u_bias_ram (
      .clock   (clock),
      .wr_en   (b_wr_en),
      .wr_addr (req_bus.index[K_W-1:0]),
      .wr_data (req_bus.value),
      .rd_addr (k_ff),
      .rd_data (b_rd)
   );

   fcl_ram #(.WIDTH(ACC_W), .DEPTH(MAX_OUT)) u_acc_ram (
      .clock   (clock),
      .wr_en   (s2_vld_ff),
      .wr_addr (s2_k_ff),
      .wr_data (acc_wr_data),
      .rd_addr (k_ff),
      .rd_data (acc_rd)
   );

   // mac pipeline: read, multiply, accumulate and write back
   assign s1_vld_in   = (state_ff == ST_MAC);
   assign s1_k_in     = k_ff;
   assign s1_accv_in  = acc_vld_ff[k_ff];
   assign s2_vld_in   = s1_vld_ff;
   assign s2_k_in     = s1_k_ff;
   assign prod_in     = act_ff * $signed(w_rd);
   assign s2_acc_in   = s1_accv_ff ? $signed(acc_rd) : '0;
   assign acc_wr_data = s2_acc_ff + {{(ACC_W - PROD_W){prod_ff[PROD_W-1]}}, prod_ff};

   // accumulator valid bits: unwritten entries read as zero
   always_comb begin
      acc_vld_in = acc_vld_ff;
      if (acc_clr) begin
         acc_vld_in = '0;
      end else if (s2_vld_ff) begin
         acc_vld_in[s2_k_ff] = 1'b1;
      end
   end

   // result datapath
   assign acc_sel   = o_accv_ff ? $signed(acc_rd) : '0;
   assign acc_shift = acc_sel >>> frac_ff;
   assign sum_in    = {{(SUM_W - DATA_WIDTH){b_rd[DATA_WIDTH-1]}}, b_rd}
                      + {acc_shift[ACC_W-1], acc_shift};

   always_comb begin
      clip_sat = 1'b0;
      clip_val = sum_ff[DATA_WIDTH-1:0];
      if (sum_ff > SAT_HI) begin
         clip_sat = 1'b1;
         clip_val = SAT_HI[DATA_WIDTH-1:0];
      end else if (sum_ff < SAT_LO) begin
         clip_sat = 1'b1;
         clip_val = SAT_LO[DATA_WIDTH-1:0];
      end
      relu_val = (relu_ff && clip_val[DATA_WIDTH-1]) ? '0 : clip_val;
   end

   // next state and outputs of the sequencer
   always_comb begin
      state_in    = state_ff;
      k_in        = k_ff;
      addr_in     = addr_ff;
      pos_in      = pos_ff;
      done_in     = done_ff;
      act_in      = act_ff;
      acc_clr     = 1'b0;
      o_accv_in   = o_accv_ff;
      best_val_in = best_val_ff;
      best_idx_in = best_idx_ff;
      rsp_vld_in  = rsp_vld_ff;
      res_in      = res_ff;
      oidx_in     = oidx_ff;
      last_in     = last_ff;
      sat_in      = sat_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire && (req_bus.action == ACT_FEED)) begin
               act_in   = req_bus.value;
               k_in     = '0;
               addr_in  = WA_W'(pos_ff);
               done_in  = !((NI_W'(pos_ff) + NI_W'(1)) < ni);
               if ((NI_W'(pos_ff) + NI_W'(1)) < ni) begin
                  pos_in = pos_ff + POS_W'(1);
               end
               state_in = ST_MAC;
            end
         end
         ST_MAC: begin
            if (k_is_last) begin
               state_in = ST_DRAIN;
            end else begin
               k_in    = k_ff + K_W'(1);
               addr_in = addr_ff + WA_W'(ni);
            end
         end
         ST_DRAIN: begin
            if (!s1_vld_ff && !s2_vld_ff) begin
               if (done_ff) begin
                  k_in     = '0;
                  state_in = ST_RD;
               end else begin
                  state_in = ST_IDLE;
               end
            end
         end
         ST_RD: begin
            o_accv_in = acc_vld_ff[k_ff];
            state_in  = ST_SUM;
         end
         ST_SUM: begin
            state_in = ST_SAT;
         end
         ST_SAT: begin
            if ((k_ff == '0) || (relu_val > best_val_ff)) begin
               best_val_in = relu_val;
               best_idx_in = k_ff;
            end
            res_in     = relu_val;
            sat_in     = clip_sat;
            oidx_in    = k_ff;
            last_in    = k_is_last;
            rsp_vld_in = 1'b1;
            state_in   = ST_HOLD;
         end
         ST_HOLD: begin
            if (rsp_bus.ready) begin
               rsp_vld_in = 1'b0;
               if (last_ff) begin
                  acc_clr  = 1'b1;
                  pos_in   = '0;
                  state_in = ST_IDLE;
               end else begin
                  k_in     = k_ff + K_W'(1);
                  state_in = ST_RD;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // sequencer registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         pos_ff     <= '0;
         acc_vld_ff <= '0;
         rsp_vld_ff <= 1'b0;
         s1_vld_ff  <= 1'b0;
         s2_vld_ff  <= 1'b0;
         k_ff       <= '0;
         done_ff    <= 1'b0;
      end else begin
         state_ff   <= state_in;
         pos_ff     <= pos_in;
         acc_vld_ff <= acc_vld_in;
         rsp_vld_ff <= rsp_vld_in;
         s1_vld_ff  <= s1_vld_in;
         s2_vld_ff  <= s2_vld_in;
         k_ff       <= k_in;
         done_ff    <= done_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      addr_ff     <= addr_in;
      act_ff      <= act_in;
      s1_k_ff     <= s1_k_in;
      s1_accv_ff  <= s1_accv_in;
      s2_k_ff     <= s2_k_in;
      prod_ff     <= prod_in;
      s2_acc_ff   <= s2_acc_in;
      o_accv_ff   <= o_accv_in;
      sum_ff      <= sum_in;
      best_val_ff <= best_val_in;
      best_idx_ff <= best_idx_in;
      res_ff      <= res_in;
      oidx_ff     <= oidx_in;
      last_ff     <= last_in;
      sat_ff      <= sat_in;
   end

   // result channel
   assign rsp_bus.valid        = rsp_vld_ff;
   assign rsp_bus.result_value = res_ff;
   assign rsp_bus.out_index    = OUT_IDX_W'(oidx_ff);
   assign rsp_bus.last         = last_ff;
   assign rsp_bus.best_index   = OUT_IDX_W'(best_idx_ff);
   assign rsp_bus.best_value   = best_val_ff;
   assign rsp_bus.saturated    = sat_ff;
endmodule

// ===== design/fcl_checker.sv =====
// port-level checks of the fully connected layer, bound to the top level
`timescale 1ns / 1ps
module fcl_checker import fcl_pkg::*; (
   input logic                         clock,
   input logic                         reset,
   input logic                         req_ready,
   input logic                         rsp_valid,
   input logic                         rsp_ready,
   input logic signed [DATA_WIDTH-1:0] rsp_result_value,
   input logic [OUT_IDX_W-1:0]         rsp_out_index,
   input logic [OUT_IDX_W-1:0]         rsp_best_index,
   input logic signed [DATA_WIDTH-1:0] rsp_best_value
);
   // a stalled result holds its value
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_result_value))
      else $error("stalled result changed");

   // no new request is taken while a result is pending
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !req_ready)
      else $error("request accepted while result pending");

   // the first output of a sample is its own argmax
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_out_index == '0) |-> (rsp_best_index == '0)
         && (rsp_best_value == rsp_result_value))
      else $error("argmax wrong on first output");

   // the running maximum never falls below the current output
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_best_value >= rsp_result_value))
      else $error("running maximum below current output");
endmodule

bind fully_connected_layer_relu fcl_checker u_fcl_checker (
   .clock            (clock),
   .reset            (reset),
   .req_ready        (req_bus.ready),
   .rsp_valid        (rsp_bus.valid),
   .rsp_ready        (rsp_bus.ready),
   .rsp_result_value (rsp_bus.result_value),
   .rsp_out_index    (rsp_bus.out_index),
   .rsp_best_index   (rsp_bus.best_index),
   .rsp_best_value   (rsp_bus.best_value)
);
